### rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file imports this package.
package spq_pkg;

   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 16;

   // Operation codes carried on the request channel
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // One stored entry of the chain
   typedef struct packed {
      logic                     valid;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
   } spq_entry_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic                      insert;
      logic                      remove;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
   } spq_cmd_type;

endpackage

### rtl/spq_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on spq_pkg for field widths.
interface spq_req_if;
   import spq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic signed [VALUE_W-1:0] item_value;
   logic signed [PRIO_W-1:0]  item_priority;

   modport source (output valid, output operation, output item_value,
                   output item_priority, input ready);
   modport sink   (input valid, input operation, input item_value,
                   input item_priority, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] head_value;
   logic signed [PRIO_W-1:0]  head_priority;
   logic                      is_empty;
   logic                      insert_dropped;

   modport source (output valid, output head_value, output head_priority,
                   output is_empty, output insert_dropped, input ready);
   modport sink   (input valid, input head_value, input head_priority,
                   input is_empty, input insert_dropped, output ready);
endinterface

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with neighbors.
// Depends on spq_pkg for the entry and command types.
module spq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  spq_pkg::spq_cmd_type   cmd,
   input  spq_pkg::spq_entry_type left_entry,
   input  logic                  left_flag,
   input  spq_pkg::spq_entry_type right_entry,
   output spq_pkg::spq_entry_type entry,
   output logic                  flag
);
   import spq_pkg::*;

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // New item belongs here or earlier: slot empty or strictly lower priority
   assign flag = !entry_ff.valid || (entry_ff.prio < cmd.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (left_flag) begin
            entry_in = left_entry;
         end else if (flag) begin
            entry_in.valid = 1'b1;
            entry_in.value = cmd.value;
            entry_in.prio  = cmd.prio;
         end
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

### rtl/sorted_priority_queue.sv
// Sorted priority queue: a row of QUEUE_DEPTH cells kept in priority order.
// Depends on spq_pkg, spq_if (channel interfaces) and spq_cell.
//
// Usage:
//   req_chan carries one operation per transfer: insert (item_value with
//   item_priority) or remove of the head entry. rsp_chan returns exactly one
//   result per request: the head value and priority after the operation
//   (both all ones when empty), is_empty, and insert_dropped when an insert
//   met a full queue and was discarded.
//   Inserts land behind every entry of equal or higher priority, so equal
//   priorities leave in arrival order. A remove on an empty queue is a no-op.
// Timing:
//   The result appears in the cycle after the request transfer. One request
//   is taken every cycle unless a result stalls; each cell decides its next
//   entry from itself and its two neighbors, so the whole chain shifts at once.
// Reset:
//   Synchronous reset clears all cell valid bits (empty queue) and the
//   response register.
// Stall:
//   While a result waits on rsp_chan, req_chan.ready drops; it rises again in
//   the cycle the result is taken, so a new request can transfer alongside.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   spq_req_if.sink    req_chan,
   spq_rsp_if.source  rsp_chan
);
   import spq_pkg::*;

   spq_entry_type              entries [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]     flags;
   logic [QUEUE_DEPTH-1:0]     valid_vec;
   spq_cmd_type                cmd;
   logic                       accept;
   logic                       full;

   logic rsp_valid_ff, rsp_valid_in;
   logic dropped_ff, dropped_in;

   // Request side: accept whenever the response register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = valid_vec[QUEUE_DEPTH-1];

   // Broadcast the command; drop an insert into a full chain
   always_comb begin
      cmd.insert = accept && (req_chan.operation == OP_INSERT) && !full;
      cmd.remove = accept && (req_chan.operation == OP_REMOVE);
      cmd.value  = req_chan.item_value;
      cmd.prio   = req_chan.item_priority;
   end

   // Chain of cells: left neighbor feeds inserts, right neighbor feeds removes
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_entry_type left_entry;
      spq_entry_type right_entry;
      logic          left_flag;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_flag  = 1'b0;
      end else begin : g_inner
         assign left_entry = entries[i-1];
         assign left_flag  = flags[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid
         assign right_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_flag   (left_flag),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .flag        (flags[i])
      );

      assign valid_vec[i] = entries[i].valid;
   end

   // Response register: hold while stalled, load on every request transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      dropped_in   = dropped_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         dropped_in   = (req_chan.operation == OP_INSERT) && full;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         dropped_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         dropped_ff   <= dropped_in;
      end
   end

   // Head cell already reflects the latest transfer; requests stall with it
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.is_empty       = !entries[0].valid;
   assign rsp_chan.head_value     = entries[0].valid ? entries[0].value : '1;
   assign rsp_chan.head_priority  = entries[0].valid ? entries[0].prio  : '1;
   assign rsp_chan.insert_dropped = dropped_ff;

   // Occupied cells form a contiguous run from the head
   a_thermometer: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0)
      else $error("occupied cells are not contiguous from the head");

   // Entries stay in non-increasing priority order
   for (genvar k = 1; k < QUEUE_DEPTH; k++) begin : g_order_chk
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         entries[k].valid |-> (entries[k-1].prio >= entries[k].prio))
         else $error("chain out of priority order");
   end

   // An insert into a full chain is reported as dropped
   a_drop: assert property (@(posedge clock) disable iff (reset)
      accept && (req_chan.operation == OP_INSERT) && full |=>
         rsp_chan.valid && rsp_chan.insert_dropped)
      else $error("insert into full queue not flagged");

   // Removing the only entry leaves the queue empty
   a_last_remove: assert property (@(posedge clock) disable iff (reset)
      cmd.remove && (valid_vec == QUEUE_DEPTH'(1)) |=> rsp_chan.is_empty)
      else $error("queue not empty after removing last entry");

   // No new request while a result is stalled
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !accept)
      else $error("request taken while response stalled");

endmodule
